// ===== src/assert_macros.svh =====
// Assertion macros used by the deque top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Checked on every rising clk edge once rst_n is released.
`define DQ_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("deque assertion failed");

// Checked on every rising clk edge, reset included.
`define DQ_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("deque assertion failed");

`else

`define DQ_ASSERT(lbl, prop)
`define DQ_ASSERT_ALWAYS(lbl, prop)

`endif

`endif

// ===== src/dq_pkg.sv =====
// Package with the sizes, codes and types of the double-ended queue.
package dq_pkg;

  localparam int DEPTH       = 64;
  localparam int WORD_BITS   = 32;
  localparam int IDX_W       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int OCC_W       = $clog2(DEPTH + 1);
  localparam int GROUP_CELLS = 8;
  localparam int NUM_GROUPS  = (DEPTH + GROUP_CELLS - 1) / GROUP_CELLS;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic [IDX_W-1:0] idx_t;
  typedef logic [OCC_W-1:0] occ_t;

  typedef enum logic [1:0] {
    MODE_PUSH   = 2'd0,
    MODE_POP    = 2'd1,
    MODE_INJECT = 2'd2,
    MODE_EJECT  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    STATUS_DONE  = 2'd0,
    STATUS_FULL  = 2'd1,
    STATUS_EMPTY = 2'd2
  } status_t;

  // The operation every cell of the chain performs at a clock edge.
  typedef enum logic [1:0] {
    CELL_HOLD        = 2'd0,
    CELL_SHIFT_BACK  = 2'd1,
    CELL_SHIFT_FRONT = 2'd2,
    CELL_LOAD_TAIL   = 2'd3
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    word_t    word;
    occ_t     occ;
  } cell_cmd_t;

  localparam occ_t OCC_FULL = occ_t'(DEPTH);

endpackage

// ===== src/double_ended_queue.sv =====
// Top level of the double-ended queue built as a chain of storage cells.
//
// The queue holds up to DEPTH signed words in a row of cells kept packed from
// cell 0: cell 0 is always the front and the cell just below the occupancy
// count is the back. A push shifts the whole row one cell toward the back and
// loads the new word into cell 0; a pop shifts the row toward the front and
// returns what cell 0 held; an inject loads the first free cell. For each of
// those the result beat is registered at the accept edge. An eject needs the
// word at the back, which a two-level OR tree gathers from the cell that marks
// itself as the tail; the tree's group registers load at the accept edge and
// the result register is written from the tree in the ST_EJECT state that
// follows. A request is served one at a time: a new input beat is taken when
// no eject is in flight and the output register is empty or is drained in the
// same cycle. Inserts into a full queue and removals from an empty queue leave
// the cells alone and only report their status. No clearing pass is needed
// after reset; the cells are read only where the count says they hold a word.
`include "assert_macros.svh"

module double_ended_queue
  import dq_pkg::*;
(
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [1:0]                  in_mode,
  input  logic signed [WORD_BITS-1:0] in_value,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic signed [WORD_BITS-1:0] out_value_out,
  output logic [1:0]                  out_status
);

  // One-hot control states: ready for a beat, or finishing an eject.
  typedef enum logic [1:0] {
    ST_READY = 2'b01,
    ST_EJECT = 2'b10
  } state_t;

  state_t    state_r, state_nxt;
  occ_t      occ_r, occ_nxt;
  logic      out_valid_r, out_valid_nxt;
  word_t     out_value_r, out_value_nxt;
  status_t   out_status_r, out_status_nxt;

  logic      in_accept;
  mode_t     mode;
  logic      is_insert;
  logic      queue_full;
  logic      queue_empty;
  logic      op_ok;
  logic      start_eject;
  cell_cmd_t cmd;
  word_t     cell_data [DEPTH];
  word_t     cell_tap  [DEPTH];
  word_t     back_word;

  assign mode = mode_t'(in_mode);

  // New beats wait while an eject finishes or the result slot stays full.
  assign in_stall  = (state_r != ST_READY) || (out_valid_r && out_stall);
  assign in_accept = in_valid && !in_stall;

  assign is_insert   = (mode == MODE_PUSH) || (mode == MODE_INJECT);
  assign queue_full  = (occ_r == OCC_FULL);
  assign queue_empty = (occ_r == '0);
  assign op_ok       = is_insert ? !queue_full : !queue_empty;
  assign start_eject = in_accept && op_ok && (mode == MODE_EJECT);

  // Command broadcast to every cell; the cells compare the count themselves.
  always_comb begin
    cmd.word = in_value;
    cmd.occ  = occ_r;
    cmd.op   = CELL_HOLD;
    if (in_accept && op_ok) begin
      unique case (mode)
        MODE_PUSH:   cmd.op = CELL_SHIFT_BACK;
        MODE_POP:    cmd.op = CELL_SHIFT_FRONT;
        MODE_INJECT: cmd.op = CELL_LOAD_TAIL;
        MODE_EJECT:  cmd.op = CELL_HOLD;
        default:     cmd.op = CELL_HOLD;
      endcase
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    word_t front_in;
    word_t back_in;

    if (i == 0) begin : g_head
      assign front_in = in_value;
    end else begin : g_body
      assign front_in = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_tail
      assign back_in = cell_data[i];
    end else begin : g_inner
      assign back_in = cell_data[i+1];
    end

    dq_cell u_cell (
      .clk        (clk),
      .cmd        (cmd),
      .idx        (idx_t'(i)),
      .from_front (front_in),
      .from_back  (back_in),
      .data       (cell_data[i]),
      .tap        (cell_tap[i])
    );
  end

  dq_or_tree u_tree (
    .clk    (clk),
    .load   (start_eject),
    .taps   (cell_tap),
    .result (back_word)
  );

  // Occupancy count: it alone decides full and empty.
  always_comb begin
    occ_nxt = occ_r;
    if (in_accept && op_ok) begin
      if (is_insert) begin
        occ_nxt = occ_r + occ_t'(1);
      end else begin
        occ_nxt = occ_r - occ_t'(1);
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_READY: state_nxt = start_eject ? ST_EJECT : ST_READY;
      ST_EJECT: state_nxt = ST_READY;
      default:  state_nxt = ST_READY;
    endcase
  end

  // Result register. A successful eject's beat is written from the tree in the
  // ST_EJECT state; every other request writes its beat at the accept edge.
  always_comb begin
    out_valid_nxt  = out_valid_r && out_stall;
    out_value_nxt  = out_value_r;
    out_status_nxt = out_status_r;
    priority if (state_r == ST_EJECT) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = back_word;
      out_status_nxt = STATUS_DONE;
    end else if (in_accept && !start_eject) begin
      out_valid_nxt  = 1'b1;
      out_value_nxt  = (op_ok && (mode == MODE_POP)) ? cell_data[0] : '0;
      if (op_ok) begin
        out_status_nxt = STATUS_DONE;
      end else if (is_insert) begin
        out_status_nxt = STATUS_FULL;
      end else begin
        out_status_nxt = STATUS_EMPTY;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_READY;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_value_out = out_value_r;
  assign out_status    = out_status_r;

  // The count never passes the number of cells.
  `DQ_ASSERT(a_occ_bounded, occ_r <= OCC_FULL)
  // An eject in flight always finds the result slot free.
  `DQ_ASSERT(a_eject_slot_free, (state_r == ST_EJECT) |-> !out_valid_r)
  // Every accepted request other than a real eject yields a beat next cycle.
  `DQ_ASSERT(a_beat_follows, (in_accept && !start_eject) |=> out_valid_r)
  // A successful eject yields its beat from the ST_EJECT state, once the tree's group registers have loaded.
  `DQ_ASSERT(a_eject_beat, start_eject |=> ##1 out_valid_r)
  // Reset leaves no beat pending.
  `DQ_ASSERT_ALWAYS(a_reset_clears, !rst_n |=> !out_valid_r)

endmodule

// ===== src/dq_cell.sv =====
// One storage cell of the deque chain.
module dq_cell
  import dq_pkg::*;
(
  input  logic      clk,
  input  cell_cmd_t cmd,
  input  idx_t      idx,
  input  word_t     from_front,
  input  word_t     from_back,
  output word_t     data,
  output word_t     tap
);

  word_t data_r;
  word_t data_nxt;
  occ_t  own_pos;
  occ_t  next_pos;

  assign own_pos  = occ_t'(idx);
  assign next_pos = occ_t'(idx) + occ_t'(1);

  always_comb begin
    data_nxt = data_r;
    unique case (cmd.op)
      CELL_HOLD:        data_nxt = data_r;
      CELL_SHIFT_BACK:  data_nxt = from_front;
      CELL_SHIFT_FRONT: data_nxt = from_back;
      CELL_LOAD_TAIL:   data_nxt = (cmd.occ == own_pos) ? cmd.word : data_r;
      default:          data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  // The cell holding the back word offers it to the collection tree.
  assign data = data_r;
  assign tap  = (cmd.occ == next_pos) ? data_r : '0;

endmodule

// ===== src/dq_or_tree.sv =====
// Two-level registered OR tree that collects the back word of the chain.
module dq_or_tree
  import dq_pkg::*;
(
  input  logic  clk,
  input  logic  load,
  input  word_t taps [DEPTH],
  output word_t result
);

  word_t group_r   [NUM_GROUPS];
  word_t group_nxt [NUM_GROUPS];

  always_comb begin
    for (int g = 0; g < NUM_GROUPS; g++) begin
      group_nxt[g] = '0;
      for (int c = 0; c < GROUP_CELLS; c++) begin
        if (g * GROUP_CELLS + c < DEPTH) begin
          group_nxt[g] = group_nxt[g] | taps[g * GROUP_CELLS + c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        group_r[g] <= group_nxt[g];
      end
    end
  end

  always_comb begin
    result = '0;
    for (int g = 0; g < NUM_GROUPS; g++) begin
      result = result | group_r[g];
    end
  end

endmodule
